@@ sv/motor_feedback_frame_demux_unit_defines.svh @@
// ----------------------------------------------------------------------------
// motor feedback frame demux - assertion macros
// concurrent checks on clk with reset rst_n, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_FRAME_DEMUX_UNIT_DEFINES_SVH
`define MOTOR_FEEDBACK_FRAME_DEMUX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MFD_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
// next-cycle implication
`define MFD_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define MFD_ASSERT_IMP(lbl, cond, prop, msg)
`define MFD_ASSERT_NXT(lbl, cond, prop, msg)
`endif

`endif

@@ sv/mfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// shared types and codes of the motor feedback frame demux
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int MAX_MOTORS_DEF = 8;

    // outcome codes
    localparam logic [2:0] OUTCOME_REGISTERED = 3'd0;
    localparam logic [2:0] OUTCOME_REJECTED   = 3'd1;
    localparam logic [2:0] OUTCOME_DROPPED    = 3'd2;
    localparam logic [2:0] OUTCOME_FEEDBACK   = 3'd3;
    localparam logic [2:0] OUTCOME_PARAM      = 3'd4;
    localparam logic [2:0] OUTCOME_IGNORED    = 3'd5;

    // command types from identifier bits 28:24
    localparam logic [4:0] CTYPE_FEEDBACK = 5'h02;
    localparam logic [4:0] CTYPE_PARAM    = 5'h11;

    localparam logic [3:0] FRAME_LEN_FULL = 4'd8;

    typedef struct packed {
        logic        mode;
        logic [7:0]  new_motor_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  frame_length;
        logic [28:0] frame_id;
        logic [63:0] payload;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [2:0]  slot;
        logic [7:0]  motor_id_out;
        logic [15:0] position_code;
        logic [15:0] velocity_code;
        logic [15:0] torque_code;
        logic [15:0] temperature_code;
        logic [1:0]  run_state;
        logic [5:0]  fault_bits;
        logic [15:0] param_index;
        logic [31:0] param_value_bits;
        logic [31:0] stamp_ms;
    } result_t;

    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] vel;
        logic [15:0] trq;
        logic [15:0] temp;
        logic [1:0]  run;
        logic [5:0]  flt;
        logic [31:0] stamp;
    } fb_rec_t;

    typedef struct packed {
        logic [15:0] idx;
        logic [31:0] val;
    } rp_rec_t;

    typedef struct packed {
        logic hit;
        logic full;
    } lookup_t;

endpackage

@@ sv/mfd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mfd_pkg::MAX_MOTORS_DEF
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mfd_id_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_id_table
// registered motor ids with parallel match and append
// ----------------------------------------------------------------------------
module mfd_id_table #(
    parameter int MAX_MOTORS = mfd_pkg::MAX_MOTORS_DEF,
    localparam int SW = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      lookup_id,
    input  logic            wr_en,
    input  logic [7:0]      wr_id,
    output mfd_pkg::lookup_t status,
    output logic [SW-1:0]   hit_slot,
    output logic [SW-1:0]   free_slot
);

    localparam int CW = $clog2(MAX_MOTORS + 1);

    logic [7:0]            id_reg [MAX_MOTORS];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [MAX_MOTORS-1:0] hit_vec;
    logic [SW-1:0]         slot_acc;

    // ids are unique, so at most one entry matches
    always_comb
    begin
        slot_acc = '0;
        for (int i = 0; i < MAX_MOTORS; i++)
        begin
            hit_vec[i] = (CW'(i) < count_reg) && (id_reg[i] == lookup_id);
            slot_acc   = slot_acc | (hit_vec[i] ? SW'(i) : '0);
        end
    end

    assign hit_slot    = slot_acc;
    assign status.hit  = |hit_vec;
    assign status.full = (count_reg == CW'(MAX_MOTORS));
    assign free_slot   = SW'(count_reg);
    assign count_next  = count_reg + ((wr_en && !status.full) ? CW'(1) : CW'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !status.full)
        begin
            id_reg[free_slot] <= wr_id;
        end
    end

endmodule

@@ sv/motor_feedback_frame_demux_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_frame_demux_unit
// registers motor ids and files feedback and parameter-reply frames into
// per-motor records, one result per request
// ----------------------------------------------------------------------------
//
//  channel   payload                   handshake              direction
//  item      mfd_pkg::item_t   (item)  item_valid/item_stall  in
//  result    mfd_pkg::result_t (result) result_valid/result_stall out
//
//  the id match and record read issue on the accept edge, the record
//  ram answers in the next cycle and the write-back happens as the result
//  is loaded; only one request is in flight
//  reset clears the id count and the record valid bits at once, no sweep;
//  a slot whose valid bit is clear reads as an all-zero record
//  a stalled result holds the write-back stage, so item_stall stays high
//  until the output register can take the result
//
`include "motor_feedback_frame_demux_unit_defines.svh"

module motor_feedback_frame_demux_unit #(
    parameter int MAX_MOTORS = mfd_pkg::MAX_MOTORS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  mfd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output mfd_pkg::result_t result
);

    localparam int SW = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;

    // ------------------------------------------------------------------
    // accept stage: lookup and decode
    // ------------------------------------------------------------------
    logic             accept;
    logic [7:0]       lookup_id;
    logic             frame_ok;
    logic [4:0]       ctype;
    mfd_pkg::lookup_t lk;
    logic [SW-1:0]    hit_slot;
    logic [SW-1:0]    free_slot;
    logic             has_slot;
    logic [SW-1:0]    sel_slot;
    logic [SW-1:0]    rd_slot;
    logic [2:0]       outcome;
    logic             reg_wr;
    mfd_pkg::fb_rec_t fb_new;
    mfd_pkg::rp_rec_t rp_new;

    // write-back stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [2:0]       s1_outcome_reg;
    logic             s1_has_slot_reg;
    logic [SW-1:0]    s1_slot_reg;
    logic [7:0]       s1_mid_reg;
    mfd_pkg::fb_rec_t s1_fb_reg;
    mfd_pkg::rp_rec_t s1_rp_reg;
    logic             s1_fb_vld_reg;
    logic             s1_rp_vld_reg;
    logic             s1_done;

    // record stores and their valid bits
    logic                  fb_we;
    logic                  rp_we;
    mfd_pkg::fb_rec_t      fb_rdata;
    mfd_pkg::rp_rec_t      rp_rdata;
    logic [MAX_MOTORS-1:0] fb_vld_reg;
    logic [MAX_MOTORS-1:0] fb_vld_next;
    logic [MAX_MOTORS-1:0] rp_vld_reg;
    logic [MAX_MOTORS-1:0] rp_vld_next;

    // output register
    logic             result_valid_reg;
    logic             result_valid_next;
    mfd_pkg::result_t result_reg;
    mfd_pkg::result_t result_next;
    mfd_pkg::fb_rec_t fb_cur;
    mfd_pkg::rp_rec_t rp_cur;

    assign item_stall = s1_valid_reg;
    assign accept     = item_valid && !item_stall;

    // frame motor id lives in identifier bits 15:8
    assign lookup_id = item.mode ? item.frame_id[15:8] : item.new_motor_id;
    assign frame_ok  = item.is_extended && !item.is_remote &&
                       (item.frame_length == mfd_pkg::FRAME_LEN_FULL);
    assign ctype     = item.frame_id[28:24];

    mfd_id_table #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_id_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup_id (lookup_id),
        .wr_en     (accept && reg_wr),
        .wr_id     (item.new_motor_id),
        .status    (lk),
        .hit_slot  (hit_slot),
        .free_slot (free_slot)
    );

    always_comb
    begin
        has_slot = 1'b0;
        sel_slot = hit_slot;
        outcome  = mfd_pkg::OUTCOME_DROPPED;
        reg_wr   = 1'b0;
        if (!item.mode)
        begin
            if (lk.full)
            begin
                // table full: rejected with no slot, even for a known id
                outcome = mfd_pkg::OUTCOME_REJECTED;
            end
            else if (lk.hit)
            begin
                // duplicate id shows the existing entry
                outcome  = mfd_pkg::OUTCOME_REJECTED;
                has_slot = 1'b1;
            end
            else
            begin
                outcome  = mfd_pkg::OUTCOME_REGISTERED;
                has_slot = 1'b1;
                sel_slot = free_slot;
                reg_wr   = 1'b1;
            end
        end
        else if (frame_ok && lk.hit)
        begin
            has_slot = 1'b1;
            case (ctype)
                mfd_pkg::CTYPE_FEEDBACK: outcome = mfd_pkg::OUTCOME_FEEDBACK;
                mfd_pkg::CTYPE_PARAM:    outcome = mfd_pkg::OUTCOME_PARAM;
                default:                 outcome = mfd_pkg::OUTCOME_IGNORED;
            endcase
        end
    end

    assign rd_slot = has_slot ? sel_slot : '0;

    // new feedback record: codes straight from the payload, state and
    // fault from the identifier
    always_comb
    begin
        fb_new.pos   = item.payload[63:48];
        fb_new.vel   = item.payload[47:32];
        fb_new.trq   = item.payload[31:16];
        fb_new.temp  = item.payload[15:0];
        fb_new.run   = item.frame_id[23:22];
        fb_new.flt   = item.frame_id[21:16];
        fb_new.stamp = item.now_ms;
    end

    // parameter reply: index from bytes 0..1, value from bytes 4..7,
    // both little-endian
    always_comb
    begin
        rp_new.idx = {item.payload[55:48], item.payload[63:56]};
        rp_new.val = {item.payload[7:0], item.payload[15:8],
                      item.payload[23:16], item.payload[31:24]};
    end

    // ------------------------------------------------------------------
    // write-back stage
    // ------------------------------------------------------------------
    assign s1_done       = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign s1_valid_next = accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_outcome_reg  <= outcome;
            s1_has_slot_reg <= has_slot;
            s1_slot_reg     <= rd_slot;
            s1_mid_reg      <= lookup_id;
            s1_fb_reg       <= fb_new;
            s1_rp_reg       <= rp_new;
            s1_fb_vld_reg   <= fb_vld_reg[rd_slot];
            s1_rp_vld_reg   <= rp_vld_reg[rd_slot];
        end
    end

    assign fb_we = s1_done && (s1_outcome_reg == mfd_pkg::OUTCOME_FEEDBACK);
    assign rp_we = s1_done && (s1_outcome_reg == mfd_pkg::OUTCOME_PARAM);

    mfd_ram #(
        .WIDTH ($bits(mfd_pkg::fb_rec_t)),
        .DEPTH (MAX_MOTORS)
    ) u_fb_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (s1_slot_reg),
        .wdata (s1_fb_reg),
        .re    (accept),
        .raddr (rd_slot),
        .rdata (fb_rdata)
    );

    mfd_ram #(
        .WIDTH ($bits(mfd_pkg::rp_rec_t)),
        .DEPTH (MAX_MOTORS)
    ) u_rp_ram (
        .clk   (clk),
        .we    (rp_we),
        .waddr (s1_slot_reg),
        .wdata (s1_rp_reg),
        .re    (accept),
        .raddr (rd_slot),
        .rdata (rp_rdata)
    );

    // valid bits stand in for clearing the records at reset
    always_comb
    begin
        fb_vld_next = fb_vld_reg;
        rp_vld_next = rp_vld_reg;
        if (fb_we)
        begin
            fb_vld_next[s1_slot_reg] = 1'b1;
        end
        if (rp_we)
        begin
            rp_vld_next[s1_slot_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_vld_reg <= '0;
            rp_vld_reg <= '0;
        end
        else
        begin
            fb_vld_reg <= fb_vld_next;
            rp_vld_reg <= rp_vld_next;
        end
    end

    // record shown is the one after this request's update
    always_comb
    begin
        if (s1_outcome_reg == mfd_pkg::OUTCOME_FEEDBACK)
        begin
            fb_cur = s1_fb_reg;
        end
        else
        begin
            fb_cur = s1_fb_vld_reg ? fb_rdata : '0;
        end
        if (s1_outcome_reg == mfd_pkg::OUTCOME_PARAM)
        begin
            rp_cur = s1_rp_reg;
        end
        else
        begin
            rp_cur = s1_rp_vld_reg ? rp_rdata : '0;
        end
        if (!s1_has_slot_reg)
        begin
            fb_cur = '0;
            rp_cur = '0;
        end
    end

    always_comb
    begin
        result_next.outcome          = s1_outcome_reg;
        result_next.slot             = s1_has_slot_reg ? 3'(s1_slot_reg) : 3'd0;
        result_next.motor_id_out     = s1_mid_reg;
        result_next.position_code    = fb_cur.pos;
        result_next.velocity_code    = fb_cur.vel;
        result_next.torque_code      = fb_cur.trq;
        result_next.temperature_code = fb_cur.temp;
        result_next.run_state        = fb_cur.run;
        result_next.fault_bits       = fb_cur.flt;
        result_next.param_index      = rp_cur.idx;
        result_next.param_value_bits = rp_cur.val;
        result_next.stamp_ms         = fb_cur.stamp;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    assign result_valid_next = s1_done || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `MFD_ASSERT_NXT(a_accept_enters_stage, accept, s1_valid_reg, "accepted request not in write-back stage")
    `MFD_ASSERT_NXT(a_done_loads_result, s1_done, result_valid_reg, "finished request did not reach output")
    `MFD_ASSERT_IMP(a_dropped_has_no_record, result_valid_reg && (result_reg.outcome == mfd_pkg::OUTCOME_DROPPED), (result_reg.slot == 3'd0) && (result_reg.stamp_ms == 32'd0) && (result_reg.param_index == 16'd0), "dropped frame shows a record")

endmodule

@@ sim/motor_feedback_frame_demux_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_frame_demux_unit_tb
// self-checking bench for the motor feedback frame demux: a directed table
// of registrations and bus frames, then random traffic that is mostly
// well-formed frames to registered motors, every request predicted by a
// behavioural copy of the id table and the per-slot records
// ----------------------------------------------------------------------------
module motor_feedback_frame_demux_unit_tb;

    import mfd_pkg::*;

    localparam int MOTOR_SLOTS    = MAX_MOTORS_DEF;
    localparam int RANDOM_PER_PHASE = 425;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_NS     = 5_000_000;

    // a typed-in expectation from the directed table, or none
    typedef struct {
        bit      fixed;
        result_t view;
    } typed_view_t;

    typedef struct {
        item_t   req;
        bit      fixed;
        result_t view;
    } directed_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // behavioural copy of the block state
    logic [7:0] motor_ids [MOTOR_SLOTS];
    int         motor_count;
    fb_rec_t    fb_state [MOTOR_SLOTS];
    rp_rec_t    rp_state [MOTOR_SLOTS];

    result_t       pending_views [$];
    typed_view_t   typed_views [$];
    directed_row_t directed_rows [$];

    int idle_pct;
    int stall_pct;
    bit hold_req;
    int hold_cycles;
    int mismatch_count;

    motor_feedback_frame_demux_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // table lookup limited to the slots filled so far, -1 on a miss
    function automatic int slot_of(logic [7:0] id);
        for (int i = 0; i < motor_count; i++)
        begin
            if (motor_ids[i] == id)
                return i;
        end
        return -1;
    endfunction

    // copy the stored records of a slot into a result
    function automatic result_t with_record(result_t r, int s);
        r.slot             = s[2:0];
        r.position_code    = fb_state[s].pos;
        r.velocity_code    = fb_state[s].vel;
        r.torque_code      = fb_state[s].trq;
        r.temperature_code = fb_state[s].temp;
        r.run_state        = fb_state[s].run;
        r.fault_bits       = fb_state[s].flt;
        r.stamp_ms         = fb_state[s].stamp;
        r.param_index      = rp_state[s].idx;
        r.param_value_bits = rp_state[s].val;
        return r;
    endfunction

    // apply one request to the state copy and return the record view it yields
    function automatic result_t predict_view(item_t it);
        result_t    r;
        logic [4:0] ctype;
        logic [7:0] mid;
        int         s;
        r = '0;
        if (it.mode == 1'b0)
        begin
            r.motor_id_out = it.new_motor_id;
            // a full table rejects before any lookup, so no slot is shown
            if (motor_count >= MOTOR_SLOTS)
            begin
                r.outcome = OUTCOME_REJECTED;
                return r;
            end
            s = slot_of(it.new_motor_id);
            if (s >= 0)
            begin
                r.outcome = OUTCOME_REJECTED;
                return with_record(r, s);
            end
            s = motor_count;
            motor_ids[s] = it.new_motor_id;
            motor_count++;
            r.outcome = OUTCOME_REGISTERED;
            return with_record(r, s);
        end

        ctype = it.frame_id[28:24];
        mid   = it.frame_id[15:8];
        r.motor_id_out = mid;
        s = slot_of(mid);
        // malformed frames and unknown motors show no record at all
        if (!it.is_extended || it.is_remote || it.frame_length != FRAME_LEN_FULL
            || s < 0)
        begin
            r.outcome = OUTCOME_DROPPED;
            return r;
        end

        if (ctype == CTYPE_FEEDBACK)
        begin
            fb_state[s].pos   = it.payload[63:48];
            fb_state[s].vel   = it.payload[47:32];
            fb_state[s].trq   = it.payload[31:16];
            fb_state[s].temp  = it.payload[15:0];
            fb_state[s].run   = it.frame_id[23:22];
            fb_state[s].flt   = it.frame_id[21:16];
            fb_state[s].stamp = it.now_ms;
            r.outcome = OUTCOME_FEEDBACK;
        end
        else if (ctype == CTYPE_PARAM)
        begin
            // index from bytes 0..1, value from bytes 4..7, both little-endian
            rp_state[s].idx = {it.payload[55:48], it.payload[63:56]};
            rp_state[s].val = {it.payload[7:0], it.payload[15:8],
                               it.payload[23:16], it.payload[31:24]};
            r.outcome = OUTCOME_PARAM;
        end
        else
        begin
            r.outcome = OUTCOME_IGNORED;
        end
        return with_record(r, s);
    endfunction

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------

    function automatic logic [28:0] frame_ident(logic [4:0] ctype, logic [1:0] state,
                                                logic [5:0] fault, logic [7:0] mid,
                                                logic [7:0] low);
        return {ctype, state, fault, mid, low};
    endfunction

    function automatic item_t reg_req(logic [7:0] id);
        item_t it;
        it = '0;
        it.mode = 1'b0;
        it.new_motor_id = id;
        return it;
    endfunction

    function automatic item_t frame_req(logic ext, logic rtr, logic [3:0] len,
                                        logic [28:0] fid, logic [63:0] pay,
                                        logic [31:0] now);
        item_t it;
        it = '0;
        it.mode         = 1'b1;
        it.is_extended  = ext;
        it.is_remote    = rtr;
        it.frame_length = len;
        it.frame_id     = fid;
        it.payload      = pay;
        it.now_ms       = now;
        return it;
    endfunction

    function automatic result_t plain_view(logic [2:0] outcome, logic [2:0] slot,
                                           logic [7:0] id);
        result_t r;
        r = '0;
        r.outcome      = outcome;
        r.slot         = slot;
        r.motor_id_out = id;
        return r;
    endfunction

    // mostly well-formed frames to registered motors, some registrations
    // (all rejected once the table is full) and some noise
    function automatic item_t random_request();
        item_t      it;
        logic [4:0] ctype;
        logic [7:0] mid;
        int         pick;
        it.mode         = 1'($urandom_range(1));
        it.new_motor_id = 8'($urandom_range(255));
        it.is_extended  = 1'($urandom_range(1));
        it.is_remote    = 1'($urandom_range(1));
        it.frame_length = 4'($urandom_range(8));
        it.frame_id     = 29'($urandom);
        it.payload      = {$urandom, $urandom};
        it.now_ms       = $urandom;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            it.mode = 1'b0;
            if (motor_count > 0 && $urandom_range(1) == 1)
                it.new_motor_id = motor_ids[$urandom_range(motor_count - 1)];
        end
        else if (pick < 88)
        begin
            it.mode         = 1'b1;
            it.is_extended  = 1'b1;
            it.is_remote    = 1'b0;
            it.frame_length = FRAME_LEN_FULL;
            mid = 8'($urandom_range(255));
            if (motor_count > 0 && $urandom_range(99) < 85)
                mid = motor_ids[$urandom_range(motor_count - 1)];
            pick = $urandom_range(99);
            if (pick < 40)
                ctype = CTYPE_FEEDBACK;
            else if (pick < 70)
                ctype = CTYPE_PARAM;
            else
                ctype = 5'($urandom_range(31));
            it.frame_id[28:24] = ctype;
            it.frame_id[15:8]  = mid;
        end
        else
        begin
            it.mode = 1'b1;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // request side driver
    // ------------------------------------------------------------------

    // stall is sampled at the falling edge, so the accept decision never
    // races against the block's own updates at the rising edge
    task automatic offer_request(item_t it, bit fixed, result_t view);
        bit          stalled;
        typed_view_t tv;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        tv.fixed = fixed;
        tv.view  = view;
        typed_views.push_back(tv);
        item_valid <= 1'b1;
        item       <= it;
        do
        begin
            @(negedge clk);
            stalled = item_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, with one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // block keeps offering while this side refuses, so the
                // single in-flight slot fills and the input stalls
                result_stall <= 1'b1;
                for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // scoreboard: values seen here are the ones before this edge's updates
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, result_t exp_view, result_t got_view);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch on%s: expected %h, got %h", $realtime, what,
                     exp_view, got_view);
    endtask

    always @(posedge clk)
    begin : watch
        result_t     exp_view;
        result_t     got_view;
        typed_view_t tv;
        result_t     pv;
        string       diff;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got_view = result;
                if (pending_views.size() == 0)
                begin
                    note_mismatch(" unexpected result", '0, got_view);
                end
                else
                begin
                    exp_view = pending_views.pop_front();
                    diff = "";
                    if (got_view.outcome !== exp_view.outcome)
                        diff = {diff, " outcome"};
                    if (got_view.slot !== exp_view.slot)
                        diff = {diff, " slot"};
                    if (got_view.motor_id_out !== exp_view.motor_id_out)
                        diff = {diff, " motor_id_out"};
                    if (got_view.position_code !== exp_view.position_code)
                        diff = {diff, " position_code"};
                    if (got_view.velocity_code !== exp_view.velocity_code)
                        diff = {diff, " velocity_code"};
                    if (got_view.torque_code !== exp_view.torque_code)
                        diff = {diff, " torque_code"};
                    if (got_view.temperature_code !== exp_view.temperature_code)
                        diff = {diff, " temperature_code"};
                    if (got_view.run_state !== exp_view.run_state)
                        diff = {diff, " run_state"};
                    if (got_view.fault_bits !== exp_view.fault_bits)
                        diff = {diff, " fault_bits"};
                    if (got_view.param_index !== exp_view.param_index)
                        diff = {diff, " param_index"};
                    if (got_view.param_value_bits !== exp_view.param_value_bits)
                        diff = {diff, " param_value_bits"};
                    if (got_view.stamp_ms !== exp_view.stamp_ms)
                        diff = {diff, " stamp_ms"};
                    if (diff != "")
                        note_mismatch(diff, exp_view, got_view);
                end
            end
            if (item_valid && !item_stall)
            begin
                // the predictor always runs to keep its state in step
                pv = predict_view(item);
                tv.fixed = 1'b0;
                if (typed_views.size() != 0)
                    tv = typed_views.pop_front();
                pending_views.push_back(tv.fixed ? tv.view : pv);
            end
        end
    end

    // ------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------
    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        result_t feedback_full;
        int      phase_idle [4];
        int      phase_stall [4];

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 1'b0;
        mismatch_count = 0;
        motor_count    = 0;
        for (int i = 0; i < MOTOR_SLOTS; i++)
        begin
            motor_ids[i] = '0;
            fb_state[i]  = '0;
            rp_state[i]  = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed table ---
        // frame to a motor not yet registered
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(CTYPE_FEEDBACK, 2'd1, 6'h2A, 8'h00, 8'h00),
            64'h1111_2222_3333_4444, 32'd5),
            1'b1, plain_view(OUTCOME_DROPPED, 3'd0, 8'h00)});
        // lowest and highest ids, then a duplicate of the first
        directed_rows.push_back('{reg_req(8'h00), 1'b1,
            plain_view(OUTCOME_REGISTERED, 3'd0, 8'h00)});
        directed_rows.push_back('{reg_req(8'hFF), 1'b1,
            plain_view(OUTCOME_REGISTERED, 3'd1, 8'hFF)});
        directed_rows.push_back('{reg_req(8'h00), 1'b1,
            plain_view(OUTCOME_REJECTED, 3'd0, 8'h00)});
        // feedback with every field at its maximum
        feedback_full = plain_view(OUTCOME_FEEDBACK, 3'd1, 8'hFF);
        feedback_full.position_code    = '1;
        feedback_full.velocity_code    = '1;
        feedback_full.torque_code      = '1;
        feedback_full.temperature_code = '1;
        feedback_full.run_state        = '1;
        feedback_full.fault_bits       = '1;
        feedback_full.stamp_ms         = '1;
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(CTYPE_FEEDBACK, 2'b11, 6'h3F, 8'hFF, 8'hFF), '1, '1),
            1'b1, feedback_full});
        // feedback with every field at zero
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(CTYPE_FEEDBACK, 2'b00, 6'h00, 8'h00, 8'h00), '0, '0),
            1'b0, '0});
        // parameter replies, all ones and a byte-order pattern
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(CTYPE_PARAM, 2'b00, 6'h00, 8'hFF, 8'h00), '1, 32'd7),
            1'b0, '0});
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(CTYPE_PARAM, 2'b10, 6'h15, 8'h00, 8'h3C),
            64'h0123_4567_89AB_CDEF, 32'd9), 1'b0, '0});
        // command types that leave the records alone
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(5'h1F, 2'b01, 6'h01, 8'hFF, 8'h00), '1, '1), 1'b0, '0});
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(5'h00, 2'b00, 6'h00, 8'h00, 8'h00), '0, '0), 1'b0, '0});
        // malformed frames to a registered motor: standard id, remote, short
        directed_rows.push_back('{frame_req(1'b0, 1'b0, FRAME_LEN_FULL,
            frame_ident(CTYPE_FEEDBACK, 2'b01, 6'h01, 8'hFF, 8'h00), '1, '1),
            1'b1, plain_view(OUTCOME_DROPPED, 3'd0, 8'hFF)});
        directed_rows.push_back('{frame_req(1'b1, 1'b1, FRAME_LEN_FULL,
            frame_ident(CTYPE_FEEDBACK, 2'b01, 6'h01, 8'hFF, 8'h00), '1, '1),
            1'b1, plain_view(OUTCOME_DROPPED, 3'd0, 8'hFF)});
        directed_rows.push_back('{frame_req(1'b1, 1'b0, 4'd0,
            frame_ident(CTYPE_PARAM, 2'b01, 6'h01, 8'h00, 8'h00), '1, '1),
            1'b1, plain_view(OUTCOME_DROPPED, 3'd0, 8'h00)});
        directed_rows.push_back('{frame_req(1'b1, 1'b0, 4'd7,
            frame_ident(CTYPE_PARAM, 2'b01, 6'h01, 8'h00, 8'h00), '1, '1),
            1'b1, plain_view(OUTCOME_DROPPED, 3'd0, 8'h00)});
        // fill the table
        directed_rows.push_back('{reg_req(8'h5A), 1'b0, '0});
        directed_rows.push_back('{reg_req(8'hA5), 1'b0, '0});
        directed_rows.push_back('{reg_req(8'h01), 1'b0, '0});
        directed_rows.push_back('{reg_req(8'h80), 1'b0, '0});
        directed_rows.push_back('{reg_req(8'h7F), 1'b0, '0});
        directed_rows.push_back('{reg_req(8'hFE), 1'b0, '0});
        // table full wins over a duplicate, so both show no slot
        directed_rows.push_back('{reg_req(8'h33), 1'b1,
            plain_view(OUTCOME_REJECTED, 3'd0, 8'h33)});
        directed_rows.push_back('{reg_req(8'hFE), 1'b1,
            plain_view(OUTCOME_REJECTED, 3'd0, 8'hFE)});
        // last slot and a middle slot
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(CTYPE_FEEDBACK, 2'b10, 6'h20, 8'hFE, 8'h81),
            64'h8000_7FFF_0001_FFFE, 32'h8000_0000), 1'b0, '0});
        directed_rows.push_back('{frame_req(1'b1, 1'b0, FRAME_LEN_FULL,
            frame_ident(CTYPE_PARAM, 2'b11, 6'h00, 8'h80, 8'h00),
            64'hFEDC_BA98_7654_3210, 32'd1), 1'b0, '0});

        foreach (directed_rows[i])
            offer_request(directed_rows[i].req, directed_rows[i].fixed,
                          directed_rows[i].view);

        // --- random phases: none, sender idle, receiver stall, both ---
        phase_idle  = '{0, 55, 0, 10};
        phase_stall = '{0, 0, 55, 10};
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            // long hold-off while the sender keeps offering flat out
            if (p == 0)
                hold_req = 1'b1;
            repeat (RANDOM_PER_PHASE)
                offer_request(random_request(), 1'b0, '0);
        end

        item_valid <= 1'b0;
        stall_pct = 0;
        while (pending_views.size() != 0 || typed_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/mfd_pkg.sv
sv/mfd_ram.sv
sv/mfd_id_table.sv
sv/motor_feedback_frame_demux_unit.sv
sim/motor_feedback_frame_demux_unit_tb.sv
